@@ hdl/lis_pkg.sv @@
// Shared types and constants for the least-loaded interrupt steering block.
// No dependencies; imported by lis_ctrl, lis_dp and the top level.
`default_nettype none

package lis_pkg;

  localparam int PID_W      = 5;
  localparam int BUS_W      = 4;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // Supported range: processors 2..32, buses 1..16 (port fields are fixed width)
  localparam int DEF_NUM_PROCESSORS = 32;
  localparam int DEF_NUM_BUSES      = 16;

  localparam logic [OP_W-1:0] OP_DISTRIBUTE = 2'd0;
  localparam logic [OP_W-1:0] OP_ENABLE     = 2'd1;
  localparam logic [OP_W-1:0] OP_DISABLE    = 2'd2;

  localparam logic KIND_ROUTE   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BUS_PRESENT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_PROC     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOOTBUS_OWNER = 2'd2;

  typedef struct packed {
    logic start;
    logic pick;
    logic scan;
    logic route;
    logic summary;
  } lis_cmd_t;

  typedef struct packed {
    logic pend_empty;
    logic scan_last;
    logic out_full;
  } lis_sts_t;

endpackage

`default_nettype wire

@@ hdl/lis_ctrl.sv @@
// Operation sequencer: walks pending buses, runs the target scan, emits results.
// Depends on lis_pkg (command and status structs).
`default_nettype none

module lis_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire lis_pkg::lis_sts_t sts_i,
  output lis_pkg::lis_cmd_t      cmd_o
);
  import lis_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_NEXT  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_ROUTE = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready_o = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_nxt   = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (sts_i.pend_empty) begin
          state_nxt = ST_SUM;
        end else begin
          cmd_o.pick = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) state_nxt = ST_ROUTE;
      end
      ST_ROUTE: begin
        if (!sts_i.out_full) begin
          cmd_o.route = 1'b1;
          state_nxt   = ST_NEXT;
        end
      end
      ST_SUM: begin
        if (!sts_i.out_full) begin
          cmd_o.summary = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd_o.start, cmd_o.pick, cmd_o.scan, cmd_o.route, cmd_o.summary}))
    else $error("more than one datapath command");

  a_no_emit_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.route || cmd_o.summary) |-> !sts_i.out_full)
    else $error("result emitted into a stalled output");

  a_scan_to_route: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.scan && sts_i.scan_last) |=> (state_r == ST_ROUTE))
    else $error("scan end did not lead to route");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.start |=> !in_ready_o)
    else $error("new transaction taken mid-operation");

endmodule

`default_nettype wire

@@ hdl/lis_dp.sv @@
// Datapath: config registers, enable/assignment state, 8-lane least-loaded scan,
// output register. Depends on lis_pkg; driven by lis_ctrl commands.
`default_nettype none

module lis_dp #(
  parameter int NUM_PROCESSORS = lis_pkg::DEF_NUM_PROCESSORS,
  parameter int NUM_BUSES      = lis_pkg::DEF_NUM_BUSES
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [lis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lis_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [lis_pkg::OP_W-1:0]       op_i,
  input  wire logic [lis_pkg::PID_W-1:0]      pid_i,
  input  wire lis_pkg::lis_cmd_t              cmd_i,
  output lis_pkg::lis_sts_t                   sts_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                out_kind_o,
  output logic [lis_pkg::BUS_W-1:0]           out_bus_o,
  output logic [lis_pkg::PID_W-1:0]           out_tgt_o,
  output logic                                out_nt_o,
  output logic                                out_busy_o,
  output logic [lis_pkg::PID_W-1:0]           out_high_o,
  output logic                                out_last_o
);
  import lis_pkg::*;

  localparam int LANES  = 8;
  localparam int LANE_W = 3;
  localparam int GROUPS = (NUM_PROCESSORS + LANES - 1) / LANES;
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int IDX_W  = GRP_W + LANE_W;
  localparam int SLOTS  = 1 << IDX_W;
  localparam int OFF_W  = IDX_W + 1;
  localparam int CNT_W  = $clog2(NUM_BUSES + 1);
  localparam int BIDX_W = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;

  // configuration
  logic [15:0]          bus_present_r;
  logic [PID_W-1:0]     boot_proc_r;
  logic [31:0]          bootbus_owner_r;

  // steering state
  logic [SLOTS-1:0]     en_r;
  logic [NUM_BUSES-1:0] mask_r [SLOTS];
  logic [CNT_W-1:0]     cnt_r  [SLOTS];
  logic [PID_W-1:0]     high_r;

  // per-operation state
  logic                 busy_r;
  logic                 nt_any_r;
  logic                 upd_hint_r;
  logic [IDX_W-1:0]     hint_r;
  logic [NUM_BUSES-1:0] pend_r;
  logic [BIDX_W-1:0]    bus_r;
  logic [GRP_W-1:0]     grp_r;
  logic                 best_vld_r;
  logic [CNT_W-1:0]     best_cnt_r;
  logic [OFF_W-1:0]     best_off_r;
  logic [IDX_W-1:0]     best_id_r;

  logic                 out_valid_r;
  logic                 out_kind_r;
  logic [BUS_W-1:0]     out_bus_r;
  logic [PID_W-1:0]     out_tgt_r;
  logic                 out_nt_r;
  logic                 out_busy_r;
  logic [PID_W-1:0]     out_high_r;
  logic                 out_last_r;

  function automatic logic [IDX_W-1:0] next_hint(input logic [PID_W-1:0] p);
    logic [PID_W:0] s;
    s = {1'b0, p} + (PID_W+1)'(1);
    if (s >= (PID_W+1)'(NUM_PROCESSORS)) s = '0;
    return s[IDX_W-1:0];
  endfunction

  // start decode
  logic                 id_ok;
  logic [IDX_W-1:0]     id_s;
  logic [SLOTS-1:0]     low_cand;
  logic                 low_found;
  logic [IDX_W-1:0]     low_id;
  logic [NUM_BUSES-1:0] present;
  logic                 is_enable;
  logic                 is_disable;
  logic [NUM_BUSES-1:0] start_pend;

  assign id_ok   = ({1'b0, pid_i} < (PID_W+1)'(NUM_PROCESSORS));
  assign id_s    = pid_i[IDX_W-1:0];
  assign present = bus_present_r[NUM_BUSES-1:0];
  assign low_cand = en_r & ((SLOTS'(1) << id_s) - SLOTS'(1));
  assign is_enable  = (op_i == OP_ENABLE) && id_ok;
  assign is_disable = (op_i == OP_DISABLE) && id_ok;
  assign start_pend = ((op_i == OP_DISTRIBUTE) || is_enable) ? present :
                      (is_disable ? mask_r[id_s] : '0);

  always_comb begin
    low_found = 1'b0;
    low_id    = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (low_cand[k]) begin
        low_found = 1'b1;
        low_id    = IDX_W'(k);
      end
    end
  end

  // lowest pending bus
  logic [BIDX_W-1:0] first_bus;
  always_comb begin
    first_bus = '0;
    for (int k = NUM_BUSES - 1; k >= 0; k--) begin
      if (pend_r[k]) first_bus = BIDX_W'(k);
    end
  end

  // one group of LANES candidates per cycle; key is (load, scan offset from hint)
  logic             c_vld;
  logic [CNT_W-1:0] c_cnt;
  logic [OFF_W-1:0] c_off;
  logic [IDX_W-1:0] c_id;
  logic [IDX_W-1:0] l_idx;
  logic [OFF_W-1:0] l_off;

  always_comb begin
    c_vld = best_vld_r;
    c_cnt = best_cnt_r;
    c_off = best_off_r;
    c_id  = best_id_r;
    l_idx = '0;
    l_off = '0;
    for (int l = 0; l < LANES; l++) begin
      l_idx = {grp_r, LANE_W'(l)};
      if (l_idx >= hint_r) l_off = {1'b0, l_idx} - {1'b0, hint_r};
      else l_off = {1'b0, l_idx} + OFF_W'(NUM_PROCESSORS) - {1'b0, hint_r};
      if (en_r[l_idx] && (!c_vld || (cnt_r[l_idx] < c_cnt) ||
                          ((cnt_r[l_idx] == c_cnt) && (l_off < c_off)))) begin
        c_vld = 1'b1;
        c_cnt = cnt_r[l_idx];
        c_off = l_off;
        c_id  = l_idx;
      end
    end
  end

  logic was_set;
  assign was_set = mask_r[best_id_r][bus_r];

  assign sts_o = '{pend_empty: (pend_r == '0),
                   scan_last:  (grp_r == GRP_W'(GROUPS - 1)),
                   out_full:   (out_valid_r && !out_ready_i)};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_present_r   <= '0;
      boot_proc_r     <= '0;
      bootbus_owner_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BUS_PRESENT:   bus_present_r   <= cfg_wdata[15:0];
        REG_BOOT_PROC:     boot_proc_r     <= cfg_wdata[PID_W-1:0];
        REG_BOOTBUS_OWNER: bootbus_owner_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // steering state and operation control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r       <= '0;
      high_r     <= '0;
      pend_r     <= '0;
      best_vld_r <= 1'b0;
      nt_any_r   <= 1'b0;
      busy_r     <= 1'b0;
      upd_hint_r <= 1'b0;
      hint_r     <= '0;
      grp_r      <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        mask_r[k] <= '0;
        cnt_r[k]  <= '0;
      end
    end else begin
      if (cmd_i.start) begin
        nt_any_r   <= 1'b0;
        busy_r     <= is_disable && ((pid_i == boot_proc_r) || bootbus_owner_r[pid_i]);
        upd_hint_r <= !is_disable;
        hint_r     <= is_disable ? next_hint(pid_i) : next_hint(boot_proc_r);
        pend_r     <= start_pend;
        case (op_i)
          OP_ENABLE: begin
            if (id_ok) begin
              en_r[id_s] <= 1'b1;
              for (int k = 0; k < SLOTS; k++) begin
                mask_r[k] <= '0;
                cnt_r[k]  <= '0;
              end
              if (pid_i > high_r) high_r <= pid_i;
            end
          end
          OP_DISABLE: begin
            if (id_ok) begin
              en_r[id_s]   <= 1'b0;
              mask_r[id_s] <= '0;
              cnt_r[id_s]  <= '0;
              if ((pid_i == high_r) && low_found) high_r <= PID_W'(low_id);
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.pick) begin
        pend_r[first_bus] <= 1'b0;
        grp_r             <= '0;
        best_vld_r        <= 1'b0;
      end
      if (cmd_i.scan) begin
        grp_r      <= grp_r + GRP_W'(1);
        best_vld_r <= c_vld;
      end
      if (cmd_i.route) begin
        if (best_vld_r) begin
          mask_r[best_id_r][bus_r] <= 1'b1;
          if (!was_set) cnt_r[best_id_r] <= cnt_r[best_id_r] + CNT_W'(1);
          if (upd_hint_r) hint_r <= next_hint(PID_W'(best_id_r));
        end else begin
          nt_any_r <= 1'b1;
        end
      end
    end
  end

  // search payload
  always_ff @(posedge clk) begin
    if (cmd_i.pick) bus_r <= first_bus;
    if (cmd_i.scan) begin
      best_cnt_r <= c_cnt;
      best_off_r <= c_off;
      best_id_r  <= c_id;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.route || cmd_i.summary) begin
      out_valid_r <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.route) begin
      out_kind_r <= KIND_ROUTE;
      out_bus_r  <= BUS_W'(bus_r);
      out_tgt_r  <= best_vld_r ? PID_W'(best_id_r) : '0;
      out_nt_r   <= !best_vld_r;
      out_busy_r <= busy_r;
      out_high_r <= high_r;
      out_last_r <= 1'b0;
    end else if (cmd_i.summary) begin
      out_kind_r <= KIND_SUMMARY;
      out_bus_r  <= '0;
      out_tgt_r  <= '0;
      out_nt_r   <= nt_any_r || (en_r == '0);
      out_busy_r <= busy_r;
      out_high_r <= high_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_kind_o  = out_kind_r;
  assign out_bus_o   = out_bus_r;
  assign out_tgt_o   = out_tgt_r;
  assign out_nt_o    = out_nt_r;
  assign out_busy_o  = out_busy_r;
  assign out_high_o  = out_high_r;
  assign out_last_o  = out_last_r;

  a_target_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.route && best_vld_r) |-> en_r[best_id_r])
    else $error("route target is not enabled");

  a_summary_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.summary |-> (pend_r == '0))
    else $error("summary with buses still pending");

  a_pick_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.pick |-> (pend_r != '0))
    else $error("bus picked from empty pending set");

endmodule

`default_nettype wire

@@ hdl/least_loaded_interrupt_steering.sv @@
// Top level of the least-loaded interrupt steering block.
// Depends on lis_pkg, lis_ctrl and lis_dp.
//
// One operation (distribute, enable or disable a processor) is taken at a time;
// in_tready is high only between operations. Each bus routed takes a pick
// step, the least-loaded scan that examines eight processors per cycle, and
// a route step that writes the result; route and summary wait while the
// output side stalls. The summary follows once no bus is left pending.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata; the user
// must write it only between operations, which the block does not enforce.
// Supported: NUM_PROCESSORS 2..32, NUM_BUSES 1..16.
`default_nettype none

module least_loaded_interrupt_steering #(
  parameter int NUM_PROCESSORS = lis_pkg::DEF_NUM_PROCESSORS,
  parameter int NUM_BUSES      = lis_pkg::DEF_NUM_BUSES
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [lis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lis_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [1:0] opcode, [6:2] processor_id, [7] zero
  input  wire logic [lis_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [3:0] bus_index, [8:4] target_processor, [9] no_target, [10] busy_res,
  // [15:11] highest_enabled
  output logic [lis_pkg::OUT_DATA_W-1:0]      out_tdata,
  // [0] kind
  output logic                                out_tuser,
  output logic                                out_tlast
);
  import lis_pkg::*;

  lis_cmd_t          cmd;
  lis_sts_t          sts;
  logic [BUS_W-1:0]  o_bus;
  logic [PID_W-1:0]  o_tgt;
  logic              o_nt;
  logic              o_busy;
  logic [PID_W-1:0]  o_high;

  lis_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_tvalid),
    .in_ready_o (in_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lis_dp #(
    .NUM_PROCESSORS (NUM_PROCESSORS),
    .NUM_BUSES      (NUM_BUSES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .op_i        (in_tdata[OP_W-1:0]),
    .pid_i       (in_tdata[OP_W+PID_W-1:OP_W]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_kind_o  (out_tuser),
    .out_bus_o   (o_bus),
    .out_tgt_o   (o_tgt),
    .out_nt_o    (o_nt),
    .out_busy_o  (o_busy),
    .out_high_o  (o_high),
    .out_last_o  (out_tlast)
  );

  assign out_tdata = {o_high, o_busy, o_nt, o_tgt, o_bus};

endmodule

`default_nettype wire
